// ===== design/bal_pkg.sv =====
`default_nettype none

package bal_pkg;

  // Default list capacity and the largest capacity the command format can carry.
  localparam int CAPACITY_DEFAULT = 16;
  localparam int CAP_LIMIT = 64;
  localparam int CNT_LIM_W = $clog2(CAP_LIMIT + 1);

  // Payload field widths.
  localparam int OP_W = 3;
  localparam int POS_W = 4;
  localparam int VAL_W = 32;
  localparam int STATUS_W = 2;
  localparam int TOTAL_W = 36;
  localparam int FILL_W = 5;

  // Depth of the command queue between the front and the back.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [OP_W-1:0] {
    OP_APPEND = 3'd0,
    OP_LIST   = 3'd1,
    OP_SUM    = 3'd2,
    OP_DELETE = 3'd3,
    OP_EDIT   = 3'd4,
    OP_CLEAR  = 3'd5
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_BADPOS = 2'd2
  } status_t;

  // Work the back end has to carry out for one request.
  typedef enum logic [2:0] {
    K_REPORT,
    K_APPEND,
    K_LIST,
    K_SUM,
    K_DELETE,
    K_EDIT
  } cmd_kind_t;

  typedef enum logic [2:0] {
    BS_IDLE,
    BS_EXEC,
    BS_LIST,
    BS_SUM,
    BS_SHIFT,
    BS_FINISH
  } back_state_t;

  typedef struct packed {
    logic [OP_W-1:0]         operation;
    logic [POS_W-1:0]        position;
    logic signed [VAL_W-1:0] new_value;
  } in_t;

  typedef struct packed {
    logic [STATUS_W-1:0]       status;
    logic signed [VAL_W-1:0]   element;
    logic                      element_valid;
    logic signed [TOTAL_W-1:0] total;
    logic [FILL_W-1:0]         fill_count;
    logic                      last;
  } out_t;

  typedef struct packed {
    cmd_kind_t               kind;
    status_t                 status;
    logic [POS_W-1:0]        pos;
    logic signed [VAL_W-1:0] value;
    logic [CNT_LIM_W-1:0]    cnt;
    logic [CNT_LIM_W-1:0]    cnt_after;
  } cmd_t;

endpackage

`default_nettype wire

// ===== design/bal_front.sv =====
`default_nettype none

module bal_front #(
  parameter int CAPACITY = bal_pkg::CAPACITY_DEFAULT
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire bal_pkg::in_t in_data,
  input  wire logic        q_full,
  output logic             push,
  output bal_pkg::cmd_t    push_data
);

  localparam int CW = $clog2(CAPACITY + 1);

  logic [CW-1:0] count_r;
  logic [CW-1:0] count_nxt;
  logic          is_full;
  logic          pos_ok;

  assign in_ready = !q_full;
  assign push = in_valid && in_ready;

  assign is_full = (count_r == CW'(CAPACITY));
  assign pos_ok = (bal_pkg::CNT_LIM_W'(in_data.position) < bal_pkg::CNT_LIM_W'(count_r));

  // The front keeps its own copy of the fill count, so it can judge each request
  // without waiting for the back end to finish earlier ones.
  always_comb begin
    count_nxt = count_r;
    push_data.kind = bal_pkg::K_REPORT;
    push_data.status = bal_pkg::ST_OK;
    push_data.pos = in_data.position;
    push_data.value = in_data.new_value;
    push_data.cnt = bal_pkg::CNT_LIM_W'(count_r);
    case (in_data.operation)
      bal_pkg::OP_APPEND: begin
        if (is_full) begin
          push_data.status = bal_pkg::ST_FULL;
        end else begin
          push_data.kind = bal_pkg::K_APPEND;
          count_nxt = count_r + CW'(1);
        end
      end
      bal_pkg::OP_LIST: begin
        if (count_r != '0) begin
          push_data.kind = bal_pkg::K_LIST;
        end
      end
      bal_pkg::OP_SUM: begin
        if (count_r != '0) begin
          push_data.kind = bal_pkg::K_SUM;
        end
      end
      bal_pkg::OP_DELETE: begin
        if (pos_ok) begin
          push_data.kind = bal_pkg::K_DELETE;
          count_nxt = count_r - CW'(1);
        end else begin
          push_data.status = bal_pkg::ST_BADPOS;
        end
      end
      bal_pkg::OP_EDIT: begin
        if (pos_ok) begin
          push_data.kind = bal_pkg::K_EDIT;
        end else begin
          push_data.status = bal_pkg::ST_BADPOS;
        end
      end
      bal_pkg::OP_CLEAR: begin
        count_nxt = '0;
      end
      default: begin
        count_nxt = count_r;
      end
    endcase
    push_data.cnt_after = bal_pkg::CNT_LIM_W'(count_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (push) begin
      count_r <= count_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== design/bal_queue.sv =====
`default_nettype none

module bal_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire bal_pkg::cmd_t push_data,
  input  wire logic          pop,
  output bal_pkg::cmd_t      pop_data,
  output logic               q_full,
  output logic               q_empty
);

  bal_pkg::cmd_t                 slot_r [bal_pkg::QUEUE_DEPTH];
  logic [bal_pkg::QPTR_W-1:0]    wptr_r;
  logic [bal_pkg::QPTR_W-1:0]    rptr_r;
  logic [bal_pkg::QCNT_W-1:0]    fill_r;

  assign q_full = (fill_r == bal_pkg::QCNT_W'(bal_pkg::QUEUE_DEPTH));
  assign q_empty = (fill_r == '0);
  assign pop_data = slot_r[rptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      fill_r <= '0;
    end else begin
      if (push) begin
        wptr_r <= wptr_r + bal_pkg::QPTR_W'(1);
      end
      if (pop) begin
        rptr_r <= rptr_r + bal_pkg::QPTR_W'(1);
      end
      if (push && !pop) begin
        fill_r <= fill_r + bal_pkg::QCNT_W'(1);
      end else if (pop && !push) begin
        fill_r <= fill_r - bal_pkg::QCNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/bal_back.sv =====
`default_nettype none

module bal_back #(
  parameter int CAPACITY = bal_pkg::CAPACITY_DEFAULT
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          q_empty,
  input  wire bal_pkg::cmd_t pop_data,
  output logic               pop,
  output logic               out_valid,
  input  wire logic          out_ready,
  output bal_pkg::out_t      out_data
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int AW = $clog2(CAPACITY);

  bal_pkg::back_state_t state_r;
  bal_pkg::back_state_t state_nxt;
  bal_pkg::cmd_t        cmd_r;
  bal_pkg::cmd_t        cmd_nxt;
  logic [CW-1:0]        idx_r;
  logic [CW-1:0]        idx_nxt;
  logic signed [bal_pkg::TOTAL_W-1:0] acc_r;
  logic signed [bal_pkg::TOTAL_W-1:0] acc_nxt;
  bal_pkg::out_t        out_r;
  logic                 out_valid_r;

  logic [bal_pkg::VAL_W-1:0] mem [CAPACITY];
  logic [bal_pkg::VAL_W-1:0] rd_data_r;
  logic                      mem_we;
  logic [AW-1:0]             mem_wa;
  logic [bal_pkg::VAL_W-1:0] mem_wd;
  logic                      rd_en;
  logic [AW-1:0]             rd_addr;

  logic                 out_free;
  logic                 emit;
  bal_pkg::out_t        emit_data;
  logic [CW-1:0]        cnt;
  logic [CW-1:0]        pos_p1;
  logic [CW-1:0]        idx_p1;
  logic [CW-1:0]        idx_m1;

  assign out_free = !out_valid_r || out_ready;
  assign cnt = cmd_r.cnt[CW-1:0];
  assign pos_p1 = CW'(cmd_r.pos) + CW'(1);
  assign idx_p1 = idx_r + CW'(1);
  assign idx_m1 = idx_r - CW'(1);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      bal_pkg::BS_IDLE: begin
        if (!q_empty) begin
          state_nxt = bal_pkg::BS_EXEC;
        end
      end
      bal_pkg::BS_EXEC: begin
        case (cmd_r.kind)
          bal_pkg::K_LIST: state_nxt = bal_pkg::BS_LIST;
          bal_pkg::K_SUM: state_nxt = bal_pkg::BS_SUM;
          bal_pkg::K_DELETE: begin
            state_nxt = (pos_p1 == cnt) ? bal_pkg::BS_FINISH : bal_pkg::BS_SHIFT;
          end
          default: state_nxt = bal_pkg::BS_FINISH;
        endcase
      end
      bal_pkg::BS_LIST: begin
        if (out_free && idx_r == cnt) begin
          state_nxt = bal_pkg::BS_IDLE;
        end
      end
      bal_pkg::BS_SUM: begin
        if (idx_r == cnt) begin
          state_nxt = bal_pkg::BS_FINISH;
        end
      end
      bal_pkg::BS_SHIFT: begin
        if (idx_p1 == cnt) begin
          state_nxt = bal_pkg::BS_FINISH;
        end
      end
      bal_pkg::BS_FINISH: begin
        if (out_free) begin
          state_nxt = bal_pkg::BS_IDLE;
        end
      end
      default: state_nxt = bal_pkg::BS_IDLE;
    endcase
  end

  always_comb begin
    pop = 1'b0;
    cmd_nxt = cmd_r;
    idx_nxt = idx_r;
    acc_nxt = acc_r;
    mem_we = 1'b0;
    mem_wa = idx_r[AW-1:0];
    mem_wd = cmd_r.value;
    rd_en = 1'b0;
    rd_addr = idx_r[AW-1:0];
    emit = 1'b0;
    emit_data.status = cmd_r.status;
    emit_data.element = '0;
    emit_data.element_valid = 1'b0;
    emit_data.total = acc_r;
    emit_data.fill_count = cmd_r.cnt_after[bal_pkg::FILL_W-1:0];
    emit_data.last = 1'b1;
    case (state_r)
      bal_pkg::BS_IDLE: begin
        pop = !q_empty;
        if (!q_empty) begin
          cmd_nxt = pop_data;
        end
      end
      bal_pkg::BS_EXEC: begin
        acc_nxt = '0;
        case (cmd_r.kind)
          bal_pkg::K_APPEND: begin
            mem_we = 1'b1;
            mem_wa = cnt[AW-1:0];
          end
          bal_pkg::K_EDIT: begin
            mem_we = 1'b1;
            mem_wa = AW'(cmd_r.pos);
          end
          bal_pkg::K_LIST, bal_pkg::K_SUM: begin
            rd_en = 1'b1;
            rd_addr = '0;
            idx_nxt = CW'(1);
          end
          bal_pkg::K_DELETE: begin
            rd_en = (pos_p1 != cnt);
            rd_addr = pos_p1[AW-1:0];
            idx_nxt = pos_p1;
          end
          default: begin
            rd_en = 1'b0;
          end
        endcase
      end
      bal_pkg::BS_LIST: begin
        // The entry already read goes out while the next one is fetched.
        if (out_free) begin
          emit = 1'b1;
          emit_data.element = rd_data_r;
          emit_data.element_valid = 1'b1;
          emit_data.total = '0;
          emit_data.last = (idx_r == cnt);
          if (idx_r != cnt) begin
            rd_en = 1'b1;
            idx_nxt = idx_p1;
          end
        end
      end
      bal_pkg::BS_SUM: begin
        acc_nxt = acc_r + {{(bal_pkg::TOTAL_W - bal_pkg::VAL_W){rd_data_r[bal_pkg::VAL_W-1]}},
                           rd_data_r};
        if (idx_r != cnt) begin
          rd_en = 1'b1;
          idx_nxt = idx_p1;
        end
      end
      bal_pkg::BS_SHIFT: begin
        mem_we = 1'b1;
        mem_wa = idx_m1[AW-1:0];
        mem_wd = rd_data_r;
        if (idx_p1 != cnt) begin
          rd_en = 1'b1;
          rd_addr = idx_p1[AW-1:0];
          idx_nxt = idx_p1;
        end
      end
      bal_pkg::BS_FINISH: begin
        emit = out_free;
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
    idx_r <= idx_nxt;
    acc_r <= acc_nxt;
    if (emit) begin
      out_r <= emit_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bal_pkg::BS_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data = out_r;

`ifndef SYNTHESIS
  a_pop_needs_data: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_empty && state_r == bal_pkg::BS_IDLE)
    else $error("command taken from an empty queue or while busy");

  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == bal_pkg::BS_IDLE |-> !mem_we)
    else $error("entry store written while idle");

  a_list_index: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == bal_pkg::BS_LIST || state_r == bal_pkg::BS_SUM)
      |-> idx_r != '0 && idx_r <= cnt)
    else $error("list walk index out of range");

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |=> $stable(out_r))
    else $error("held result overwritten");

  a_list_kind: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == bal_pkg::BS_LIST |-> cmd_r.kind == bal_pkg::K_LIST)
    else $error("list walk for a request that is not a list");
`endif

endmodule

`default_nettype wire

// ===== design/bounded_array_list_unit.sv =====
`default_nettype none

// Bounded array list: holds up to CAPACITY signed 32-bit entries and a fill count.
// Each request carries an operation: append (status full at capacity), list (one
// result per stored entry in order, the final one marked last; a single result with
// element_valid low when empty), sum (36-bit total), delete at a position (later
// entries move down by one), edit at a position, or clear. A position at or beyond
// the fill count reports a bad position and changes nothing. Every operation but a
// non-empty list gives exactly one result. A front stage accepts and judges requests
// against its own copy of the fill count and places them in a two-entry queue; a back
// stage owns the entry store (one write and one registered read port) and walks it one
// entry per cycle while the output is not stalled. List and sum walk the stored
// entries from the first; delete moves each entry after the position down, and
// append, edit, clear and rejected requests need no walk. The store's single read
// port limits each walk to one entry at a time, and the front keeps accepting while
// the queue has room.
module bounded_array_list_unit #(
  parameter int CAPACITY = bal_pkg::CAPACITY_DEFAULT
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire bal_pkg::in_t  in_data,
  output logic               out_valid,
  input  wire logic          out_ready,
  output bal_pkg::out_t      out_data
);

  // Judged requests on their way from the front to the back.
  bal_pkg::cmd_t push_data;
  bal_pkg::cmd_t pop_data;
  logic          push;
  logic          pop;
  logic          q_full;
  logic          q_empty;

  // The front accepts a request whenever the queue has room.
  bal_front #(
    .CAPACITY(CAPACITY)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_full   (q_full),
    .push     (push),
    .push_data(push_data)
  );

  bal_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_data(push_data),
    .pop      (pop),
    .pop_data (pop_data),
    .q_full   (q_full),
    .q_empty  (q_empty)
  );

  // The back carries out one request at a time and holds each result in an output
  // register until it is taken.
  bal_back #(
    .CAPACITY(CAPACITY)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_empty  (q_empty),
    .pop_data (pop_data),
    .pop      (pop),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

endmodule

`default_nettype wire
